// ===== src/wcf_pkg.sv =====
// wcf_pkg: grid geometry, word position tables and command type of the word clock encoder
// shared by the interfaces, front, queue and back; depends on nothing
package wcf_pkg;

  localparam int ROWS = 14;
  localparam int COLS = 16;
  localparam int ROW_W = $clog2(ROWS);
  localparam int HOUR_W = 5;
  localparam int MINUTE_W = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef struct packed {
    logic [3:0] r;
    logic [3:0] c;
    logic [3:0] n;
  } word_pos_t;

  // fixed words, one flag each in the command
  localparam int FW_THE = 0;
  localparam int FW_TIME = 1;
  localparam int FW_IS = 2;
  localparam int FW_HALF = 3;
  localparam int FW_A = 4;
  localparam int FW_MIN = 5;
  localparam int FW_S = 6;
  localparam int FW_PAST = 7;
  localparam int FW_TO = 8;
  localparam int FW_ON_HOUR = 9;
  localparam int FW_IN = 10;
  localparam int FW_AT = 11;
  localparam int FW_NIGHT = 12;
  localparam int FW_THE2 = 13;
  localparam int FW_AM = 14;
  localparam int FW_EVE = 15;
  localparam int FW_AFTERN = 16;
  localparam int NUM_FIXED = 17;

  localparam logic [4:0] NUM_TWENTY = 5'd19;
  localparam logic [3:0] HOUR_TWELVE = 4'd11;

  typedef struct packed {
    logic                 invalid;
    logic [NUM_FIXED-1:0] fixed;
    logic                 num_a_en;
    logic [4:0]           num_a;
    logic                 num_b_en;
    logic [4:0]           num_b;
    logic                 hour_en;
    logic [3:0]           hour_idx;
  } wcf_cmd_t;

  function automatic word_pos_t wp(input int r, input int c, input int n);
    word_pos_t w;
    w.r = 4'(r);
    w.c = 4'(c);
    w.n = 4'(n);
    return w;
  endfunction

  function automatic word_pos_t fixed_word(input int idx);
    word_pos_t w;
    case (idx)
      FW_THE:     w = wp(0, 0, 3);
      FW_TIME:    w = wp(0, 4, 4);
      FW_IS:      w = wp(0, 9, 2);
      FW_HALF:    w = wp(0, 12, 4);
      FW_A:       w = wp(0, 13, 1);
      FW_MIN:     w = wp(7, 0, 6);
      FW_S:       w = wp(7, 6, 1);
      FW_PAST:    w = wp(7, 8, 4);
      FW_TO:      w = wp(7, 11, 2);
      FW_ON_HOUR: w = wp(11, 0, 6);
      FW_IN:      w = wp(11, 7, 2);
      FW_AT:      w = wp(11, 9, 2);
      FW_NIGHT:   w = wp(12, 0, 5);
      FW_THE2:    w = wp(12, 4, 3);
      FW_AM:      w = wp(12, 8, 7);
      FW_EVE:     w = wp(13, 0, 7);
      default:    w = wp(13, 7, 9);
    endcase
    return w;
  endfunction

  // one..twenty, entry 14 is quarter
  function automatic word_pos_t num_word(input logic [4:0] idx);
    word_pos_t w;
    case (idx)
      5'd0:    w = wp(2, 12, 3);
      5'd1:    w = wp(2, 10, 3);
      5'd2:    w = wp(6, 11, 5);
      5'd3:    w = wp(5, 0, 4);
      5'd4:    w = wp(3, 8, 4);
      5'd5:    w = wp(2, 3, 3);
      5'd6:    w = wp(4, 0, 5);
      5'd7:    w = wp(3, 0, 5);
      5'd8:    w = wp(4, 8, 4);
      5'd9:    w = wp(2, 0, 3);
      5'd10:   w = wp(6, 5, 6);
      5'd11:   w = wp(6, 0, 6);
      5'd12:   w = wp(5, 8, 8);
      5'd13:   w = wp(5, 0, 8);
      5'd14:   w = wp(1, 0, 7);
      5'd15:   w = wp(2, 3, 7);
      5'd16:   w = wp(4, 0, 9);
      5'd17:   w = wp(3, 0, 8);
      5'd18:   w = wp(4, 8, 8);
      5'd19:   w = wp(1, 7, 6);
      default: w = wp(0, 0, 0);
    endcase
    return w;
  endfunction

  function automatic word_pos_t hour_word(input logic [3:0] idx);
    word_pos_t w;
    case (idx)
      4'd0:    w = wp(8, 2, 3);
      4'd1:    w = wp(8, 0, 3);
      4'd2:    w = wp(9, 5, 5);
      4'd3:    w = wp(10, 0, 4);
      4'd4:    w = wp(10, 5, 4);
      4'd5:    w = wp(8, 13, 3);
      4'd6:    w = wp(9, 0, 5);
      4'd7:    w = wp(10, 8, 5);
      4'd8:    w = wp(8, 9, 4);
      4'd9:    w = wp(10, 12, 3);
      4'd10:   w = wp(8, 4, 6);
      4'd11:   w = wp(9, 10, 6);
      default: w = wp(0, 0, 0);
    endcase
    return w;
  endfunction

  function automatic logic [COLS-1:0] word_mask(input word_pos_t w, input logic [ROW_W-1:0] row);
    logic [31:0] t;
    t = ((32'd1 << w.n) - 32'd1) << w.c;
    if (w.r == row) begin
      return t[COLS-1:0];
    end
    return '0;
  endfunction

  function automatic logic [COLS-1:0] row_lamps_of(input wcf_cmd_t cmd,
                                                   input logic [ROW_W-1:0] row);
    logic [COLS-1:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_FIXED; i++) begin
      if (cmd.fixed[i]) begin
        acc = acc | word_mask(fixed_word(i), row);
      end
    end
    if (cmd.num_a_en) begin
      acc = acc | word_mask(num_word(cmd.num_a), row);
    end
    if (cmd.num_b_en) begin
      acc = acc | word_mask(num_word(cmd.num_b), row);
    end
    if (cmd.hour_en) begin
      acc = acc | word_mask(hour_word(cmd.hour_idx), row);
    end
    return acc;
  endfunction

endpackage

// ===== src/wcf_if.sv =====
// wcf_in_if and wcf_out_if: valid/ready channels for times in and lamp rows out
// depends on wcf_pkg for field widths
interface wcf_in_if;
  import wcf_pkg::*;
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  modport source (output valid, output hour, output minute, input ready);
  modport sink (input valid, input hour, input minute, output ready);
endinterface

interface wcf_out_if;
  import wcf_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [COLS-1:0]  row_lamps;
  logic             last_row;
  logic             time_invalid;
  modport source (output valid, output row_index, output row_lamps, output last_row,
                  output time_invalid, input ready);
  modport sink (input valid, input row_index, input row_lamps, input last_row,
                input time_invalid, output ready);
endinterface

// ===== src/word_clock_frame_encoder_unit.sv =====
// word_clock_frame_encoder_unit: time of day in, fourteen lamp rows of the letter grid out
// the time beat is written into the queue, then the back loads its first row into the output register
// throughput: one row per cycle while the sink is ready, set by the single row walker in the back
// the front keeps taking times while the back works, up to the queue depth
// reset: synchronous, active high; clears queue pointers, row counter and output valid
// depends on wcf_pkg, wcf_if, wcf_front, wcf_queue, wcf_back
module word_clock_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = wcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wcf_in_if.sink     in_ch,
  wcf_out_if.source  out_ch
);
  import wcf_pkg::*;

  wcf_cmd_t front_cmd;
  wcf_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     head_valid;

  wcf_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (front_cmd)
  );

  wcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (front_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  wcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // an accepted time always has a row beat on offer once the back has been able to load it
  a_accept_gives_row: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> ##2 out_ch.valid)
    else $error("no row beat after an accepted time");

  // rows of one frame follow each other with no gap
  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_row) |=>
      (out_ch.valid && out_ch.row_index == ROW_W'($past(out_ch.row_index) + 1'b1)))
    else $error("row sequence broken inside a frame");

  // invalid times give dark rows
  a_invalid_dark: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.time_invalid) |-> (out_ch.row_lamps == '0))
    else $error("lamps lit for an invalid time");
`endif

endmodule

// ===== src/wcf_front.sv =====
// wcf_front: accepts a time beat and classifies it into the set of words to light
// depends on wcf_pkg and wcf_in_if; feeds wcf_queue
module wcf_front (
  wcf_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output wcf_pkg::wcf_cmd_t cmd
);
  import wcf_pkg::*;

  logic [HOUR_W-1:0]   h;
  logic [MINUTE_W-1:0] m;
  logic [HOUR_W-1:0]   h2;
  logic                bad;
  logic                to_side;
  logic                five_mult;

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;

  always_comb begin
    h = in_ch.hour;
    m = in_ch.minute;
    bad = (h > 5'd23) || (m > 6'd59);
    to_side = (m > 6'd30);
    five_mult = (m == 6'd5) || (m == 6'd10) || (m == 6'd15) || (m == 6'd20) ||
                (m == 6'd25) || (m == 6'd30) || (m == 6'd35) || (m == 6'd40) ||
                (m == 6'd45) || (m == 6'd50) || (m == 6'd55);
    h2 = to_side ? HOUR_W'(h + 5'd1) : h;
    cmd = '0;
    cmd.invalid = bad;
    if (!bad) begin
      cmd.fixed[FW_THE] = 1'b1;
      cmd.fixed[FW_TIME] = 1'b1;
      cmd.fixed[FW_IS] = 1'b1;
      if (m == 6'd0 && h == 5'd0) begin
        // midnight
        cmd.hour_en = 1'b1;
        cmd.hour_idx = HOUR_TWELVE;
        cmd.fixed[FW_ON_HOUR] = 1'b1;
        cmd.fixed[FW_AT] = 1'b1;
        cmd.fixed[FW_NIGHT] = 1'b1;
      end else if (m == 6'd0 && h == 5'd12) begin
        // noon
        cmd.hour_en = 1'b1;
        cmd.hour_idx = HOUR_TWELVE;
        cmd.fixed[FW_ON_HOUR] = 1'b1;
        cmd.fixed[FW_IN] = 1'b1;
        cmd.fixed[FW_THE2] = 1'b1;
        cmd.fixed[FW_AFTERN] = 1'b1;
      end else begin
        if (m == 6'd0) begin
          cmd.fixed[FW_ON_HOUR] = 1'b1;
        end else begin
          if (m <= 6'd20) begin
            cmd.num_a_en = 1'b1;
            cmd.num_a = 5'(m - 6'd1);
          end else if (m < 6'd30) begin
            cmd.num_a_en = 1'b1;
            cmd.num_a = NUM_TWENTY;
            cmd.num_b_en = 1'b1;
            cmd.num_b = 5'(m - 6'd21);
          end else if (m == 6'd30) begin
            cmd.fixed[FW_HALF] = 1'b1;
          end else if (m < 6'd40) begin
            cmd.num_a_en = 1'b1;
            cmd.num_a = NUM_TWENTY;
            cmd.num_b_en = 1'b1;
            cmd.num_b = 5'(6'd39 - m);
          end else begin
            cmd.num_a_en = 1'b1;
            cmd.num_a = 5'(6'd59 - m);
          end
          cmd.fixed[FW_PAST] = !to_side;
          cmd.fixed[FW_TO] = to_side;
        end

        cmd.hour_en = 1'b1;
        if (h2 == 5'd0 || h2 == 5'd24) begin
          cmd.hour_idx = HOUR_TWELVE;
        end else if (h2 <= 5'd12) begin
          cmd.hour_idx = 4'(h2 - 5'd1);
        end else begin
          cmd.hour_idx = 4'(h2 - 5'd13);
        end

        if (m == 6'd1 || m == 6'd59) begin
          cmd.fixed[FW_MIN] = 1'b1;
        end else if (m > 6'd1 && m < 6'd59 && !five_mult) begin
          cmd.fixed[FW_MIN] = 1'b1;
          cmd.fixed[FW_S] = 1'b1;
        end

        // time of day follows the hour as given, not the advanced one
        if (h < 5'd1 || h >= 5'd21) begin
          cmd.fixed[FW_AT] = 1'b1;
          cmd.fixed[FW_NIGHT] = 1'b1;
        end else begin
          cmd.fixed[FW_IN] = 1'b1;
          cmd.fixed[FW_THE2] = 1'b1;
          if (h < 5'd12) begin
            cmd.fixed[FW_AM] = 1'b1;
          end else if (h < 5'd18) begin
            cmd.fixed[FW_AFTERN] = 1'b1;
          end else begin
            cmd.fixed[FW_EVE] = 1'b1;
          end
        end

        if (m == 6'd15 || m == 6'd45) begin
          cmd.fixed[FW_A] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/wcf_queue.sv =====
// wcf_queue: short command queue between the front and the back
// depends on wcf_pkg for the command type
module wcf_queue #(
  parameter int DEPTH = wcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wcf_pkg::wcf_cmd_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output wcf_pkg::wcf_cmd_t head
);
  import wcf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wcf_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = CNT_W'(count + 1'b1);
    end else if (pop && !push) begin
      count_next = CNT_W'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/wcf_back.sv =====
// wcf_back: walks the grid rows of the head command, one row beat per cycle while the sink takes them
// depends on wcf_pkg and wcf_out_if; pops wcf_queue as it loads the last row
module wcf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  wcf_pkg::wcf_cmd_t head,
  output logic              pop,
  wcf_out_if.source         out_ch
);
  import wcf_pkg::*;

  logic [ROW_W-1:0] row;
  logic             load;

  // output register may refill in the same cycle its beat is taken
  assign load = head_valid && (!out_ch.valid || out_ch.ready);
  assign pop = load && (row == LAST_ROW);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      row <= '0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        row <= (row == LAST_ROW) ? '0 : ROW_W'(row + 1'b1);
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.row_index <= row;
      out_ch.row_lamps <= row_lamps_of(head, row);
      out_ch.last_row <= (row == LAST_ROW);
      out_ch.time_invalid <= head.invalid;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for word_clock_frame_encoder_unit, times in and lamp rows out
// keeps its own lamp grid forecast per time and checks every row beat; needs wcf_pkg and wcf_if
module tb_top;
  import wcf_pkg::*;

  typedef enum int {
    LW_THE, LW_TIME, LW_IS, LW_HALF, LW_A, LW_MINUTE, LW_S, LW_PAST, LW_TO,
    LW_OCLOCK, LW_IN, LW_AT, LW_NIGHT, LW_THE_PM, LW_MORNING, LW_EVENING, LW_AFTERNOON
  } lamp_word_e;

  typedef struct {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } clock_time_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COLS-1:0]  lamps;
    logic             last;
    logic             bad;
  } lamp_row_t;

  localparam int RANDOM_TIMES = 450;
  localparam int CALM_TAIL = 60;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;

  wcf_in_if  in_ch ();
  wcf_out_if out_ch ();

  word_clock_frame_encoder_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  clock_time_t     times_to_send [$];
  lamp_row_t       rows_awaited [$];
  logic [COLS-1:0] grid [ROWS];
  int              fault_tally = 0;

  always #6 clk = ~clk;

  function automatic void paint(input int r, input int c, input int n);
    logic [31:0] span;
    span = ((32'd1 << n) - 32'd1) << c;
    grid[r] = grid[r] | span[COLS-1:0];
  endfunction

  function automatic void paint_word(input lamp_word_e w);
    case (w)
      LW_THE:       paint(0, 0, 3);
      LW_TIME:      paint(0, 4, 4);
      LW_IS:        paint(0, 9, 2);
      LW_HALF:      paint(0, 12, 4);
      LW_A:         paint(0, 13, 1);
      LW_MINUTE:    paint(7, 0, 6);
      LW_S:         paint(7, 6, 1);
      LW_PAST:      paint(7, 8, 4);
      LW_TO:        paint(7, 11, 2);
      LW_OCLOCK:    paint(11, 0, 6);
      LW_IN:        paint(11, 7, 2);
      LW_AT:        paint(11, 9, 2);
      LW_NIGHT:     paint(12, 0, 5);
      LW_THE_PM:    paint(12, 4, 3);
      LW_MORNING:   paint(12, 8, 7);
      LW_EVENING:   paint(13, 0, 7);
      LW_AFTERNOON: paint(13, 7, 9);
      default:      ;
    endcase
  endfunction

  // number words one to twenty, fifteen is spelt quarter
  function automatic void paint_number(input int k);
    case (k)
      1:  paint(2, 12, 3);
      2:  paint(2, 10, 3);
      3:  paint(6, 11, 5);
      4:  paint(5, 0, 4);
      5:  paint(3, 8, 4);
      6:  paint(2, 3, 3);
      7:  paint(4, 0, 5);
      8:  paint(3, 0, 5);
      9:  paint(4, 8, 4);
      10: paint(2, 0, 3);
      11: paint(6, 5, 6);
      12: paint(6, 0, 6);
      13: paint(5, 8, 8);
      14: paint(5, 0, 8);
      15: paint(1, 0, 7);
      16: paint(2, 3, 7);
      17: paint(4, 0, 9);
      18: paint(3, 0, 8);
      19: paint(4, 8, 8);
      20: paint(1, 7, 6);
      default: ;
    endcase
  endfunction

  function automatic void paint_hour(input int k);
    case (k)
      1:  paint(8, 2, 3);
      2:  paint(8, 0, 3);
      3:  paint(9, 5, 5);
      4:  paint(10, 0, 4);
      5:  paint(10, 5, 4);
      6:  paint(8, 13, 3);
      7:  paint(9, 0, 5);
      8:  paint(10, 8, 5);
      9:  paint(8, 9, 4);
      10: paint(10, 12, 3);
      11: paint(8, 4, 6);
      12: paint(9, 10, 6);
      default: ;
    endcase
  endfunction

  // lamp grid of one time, pushed as fourteen awaited row beats
  function automatic void forecast_frame(input logic [HOUR_W-1:0] hour_in,
                                         input logic [MINUTE_W-1:0] minute_in);
    int        h;
    int        m;
    int        shown_h;
    bit        bad;
    lamp_row_t beat;
    h = int'(hour_in);
    m = int'(minute_in);
    bad = (h > 23) || (m > 59);
    for (int r = 0; r < ROWS; r++) grid[r] = '0;
    if (!bad) begin
      paint_word(LW_THE);
      paint_word(LW_TIME);
      paint_word(LW_IS);
      if (m == 0 && h == 0) begin
        paint_hour(12);
        paint_word(LW_OCLOCK);
        paint_word(LW_AT);
        paint_word(LW_NIGHT);
      end else if (m == 0 && h == 12) begin
        paint_hour(12);
        paint_word(LW_OCLOCK);
        paint_word(LW_IN);
        paint_word(LW_THE_PM);
        paint_word(LW_AFTERNOON);
      end else begin
        shown_h = h;
        if (m == 0) begin
          paint_word(LW_OCLOCK);
        end else begin
          if (m <= 20) begin
            paint_number(m);
          end else if (m < 30) begin
            paint_number(20);
            paint_number(m - 20);
          end else if (m == 30) begin
            paint_word(LW_HALF);
          end else if (m < 40) begin
            paint_number(20);
            paint_number(40 - m);
          end else begin
            paint_number(60 - m);
          end
          if (m <= 30) begin
            paint_word(LW_PAST);
          end else begin
            paint_word(LW_TO);
            shown_h = h + 1;
          end
        end
        // advanced hour past 23 wraps to twelve
        if (shown_h == 0 || shown_h == 24) paint_hour(12);
        else if (shown_h <= 12) paint_hour(shown_h);
        else paint_hour(shown_h - 12);
        if (m == 1 || m == 59) begin
          paint_word(LW_MINUTE);
        end else if (m > 1 && m < 59 && (m % 5) != 0) begin
          paint_word(LW_MINUTE);
          paint_word(LW_S);
        end
        // time of day follows the hour as given, not the advanced one
        if (h < 1 || h >= 21) begin
          paint_word(LW_AT);
          paint_word(LW_NIGHT);
        end else begin
          paint_word(LW_IN);
          paint_word(LW_THE_PM);
          if (h < 12) paint_word(LW_MORNING);
          else if (h < 18) paint_word(LW_AFTERNOON);
          else paint_word(LW_EVENING);
        end
        if (m == 15 || m == 45) paint_word(LW_A);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      beat.row = ROW_W'(r);
      beat.lamps = grid[r];
      beat.last = (r == ROWS - 1);
      beat.bad = bad;
      rows_awaited.push_back(beat);
    end
  endfunction

  function automatic void queue_time(input int h, input int m);
    clock_time_t t;
    t.hour = HOUR_W'(h);
    t.minute = MINUTE_W'(m);
    times_to_send.push_back(t);
  endfunction

  // time driver
  int send_gap = 0;
  int send_odds = 0;
  int send_cycles = 0;

  always @(posedge clk) begin
    clock_time_t t;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.hour <= '0;
      in_ch.minute <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        forecast_frame(in_ch.hour, in_ch.minute);
      end
      send_cycles++;
      if (send_cycles % 300 == 0) send_odds = $urandom_range(0, 3);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (times_to_send.size() > 0) begin
        t = times_to_send.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.hour <= t.hour;
        in_ch.minute <= t.minute;
        if (times_to_send.size() > CALM_TAIL && send_odds != 0 &&
            $urandom_range(1, 20) <= send_odds) begin
          send_gap = $urandom_range(1, 11);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // row monitor
  int stall_left = 0;
  int stall_odds = 0;
  int recv_cycles = 0;

  always @(posedge clk) begin
    lamp_row_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rows_awaited.size() == 0) begin
          fault_tally++;
          if (fault_tally <= MAX_REPORTS)
            $display("unexpected row beat: row %0d lamps %h last %b invalid %b",
                     out_ch.row_index, out_ch.row_lamps, out_ch.last_row,
                     out_ch.time_invalid);
        end else begin
          want = rows_awaited.pop_front();
          if (out_ch.row_index !== want.row || out_ch.row_lamps !== want.lamps ||
              out_ch.last_row !== want.last || out_ch.time_invalid !== want.bad) begin
            fault_tally++;
            if (fault_tally <= MAX_REPORTS) begin
              $write("row beat mismatch: expected row %0d lamps %h last %b invalid %b,",
                     want.row, want.lamps, want.last, want.bad);
              $display(" got row %0d lamps %h last %b invalid %b",
                       out_ch.row_index, out_ch.row_lamps, out_ch.last_row,
                       out_ch.time_invalid);
            end
          end
        end
      end
      recv_cycles++;
      if (recv_cycles % 300 == 150) stall_odds = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (times_to_send.size() > CALM_TAIL && stall_odds != 0 &&
                   $urandom_range(1, 20) <= stall_odds) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;

    // midnight, noon, on the hour
    queue_time(0, 0);
    queue_time(12, 0);
    queue_time(1, 0);
    queue_time(13, 0);
    queue_time(20, 0);
    // singular minute, quarters, half
    queue_time(0, 1);
    queue_time(5, 59);
    queue_time(7, 15);
    queue_time(18, 45);
    queue_time(20, 30);
    // past and to spellings, plural minutes, multiples of five
    queue_time(21, 25);
    queue_time(8, 20);
    queue_time(9, 21);
    queue_time(11, 31);
    queue_time(10, 39);
    queue_time(17, 40);
    queue_time(3, 35);
    queue_time(12, 44);
    queue_time(0, 59);
    // advanced hour wraps to twelve
    queue_time(23, 59);
    // out of range times
    queue_time(24, 0);
    queue_time(6, 60);
    queue_time(31, 63);
    queue_time(23, 63);
    queue_time(31, 0);

    for (int i = 0; i < RANDOM_TIMES; i++) begin
      if ($urandom_range(0, 9) < 8) queue_time($urandom_range(0, 23), $urandom_range(0, 59));
      else queue_time($urandom_range(0, 31), $urandom_range(0, 63));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (times_to_send.size() != 0 || in_ch.valid !== 1'b0) @(posedge clk);
    while (rows_awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fault_tally == 0 && rows_awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/wcf_pkg.sv
src/wcf_if.sv
src/wcf_front.sv
src/wcf_queue.sv
src/wcf_back.sv
src/word_clock_frame_encoder_unit.sv
tb/tb_top.sv
